/* hw/rtl/qrs_peak_detector_core_macros.svh */
// Assertion macros shared by the checker of the QRS peak detector.
`ifndef QRS_PEAK_DETECTOR_CORE_MACROS_SVH
`define QRS_PEAK_DETECTOR_CORE_MACROS_SVH

// Checks that a property holds at every clock edge outside reset.
`define QPD_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checks that a condition never holds at a clock edge outside reset.
`define QPD_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

/* hw/rtl/qpd_pkg.sv */
package qpd_pkg;

   localparam int DEF_HISTORY_DEPTH = 8;
   localparam int DEF_SAMPLE_BITS   = 16;
   localparam int DEF_COUNT_BITS    = 16;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 13;
   localparam int THR_BITS       = 17;
   localparam int DELAY_BITS     = 16;

   localparam int COEFF_BITS    = 9;
   localparam int TIMEOUT_BITS  = 8;
   localparam int SECOND_BITS   = 12;
   localparam int SB_START_BITS = 13;
   localparam int MIN_RR_BITS   = 12;
   localparam int PREBLANK_BITS = 8;
   localparam int WINDOW_BITS   = 8;
   localparam int FDELAY_BITS   = 10;

   localparam logic [COEFF_BITS-1:0]    RST_COEFF    = 9'd102;
   localparam logic [TIMEOUT_BITS-1:0]  RST_TIMEOUT  = 8'd19;
   localparam logic [SECOND_BITS-1:0]   RST_SECOND   = 12'd200;
   localparam logic [SB_START_BITS-1:0] RST_SB_START = 13'd330;
   localparam logic [MIN_RR_BITS-1:0]   RST_MIN_RR   = 12'd72;
   localparam logic [PREBLANK_BITS-1:0] RST_PREBLANK = 8'd40;
   localparam logic [WINDOW_BITS-1:0]   RST_WINDOW   = 8'd16;
   localparam logic [FDELAY_BITS-1:0]   RST_FDELAY   = 10'd57;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_COEFF,
      REG_TIMEOUT,
      REG_SECOND_LEN,
      REG_SB_START,
      REG_MIN_RR,
      REG_PREBLANK,
      REG_WINDOW,
      REG_FILTER_DELAY
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FRONT,
      ST_MED_Q,
      ST_MED_N,
      ST_MED_R,
      ST_MUL,
      ST_THR,
      ST_SB,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      MODE_LEARN,
      MODE_BEAT,
      MODE_NOISE
   } mode_type;

   typedef enum logic [1:0] {
      HIST_QRS,
      HIST_NOISE,
      HIST_RR
   } hist_sel_type;

   typedef struct packed {
      logic         load;
      logic         front;
      logic         med_run;
      hist_sel_type med_sel;
      logic         mul;
      logic         thr;
      logic         sb;
      logic         out_load;
   } cmd_type;

   typedef struct packed {
      logic learn_done;
      logic beat;
      logic noise;
      logic detecting;
      logic med_done;
      logic sb_hit;
   } status_type;

endpackage

/* hw/rtl/qpd_median.sv */
module qpd_median #(
   parameter int HISTORY_DEPTH = 8,
   parameter int MED_BITS      = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    run,
   input  logic [HISTORY_DEPTH-1:0][MED_BITS-1:0]  hist,
   output logic                                    done,
   output logic [MED_BITS-1:0]                     result
);
   localparam int IW   = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int CNTW = $clog2(HISTORY_DEPTH + 1);
   localparam logic [CNTW-1:0] RANK = CNTW'(HISTORY_DEPTH - 1 - HISTORY_DEPTH / 2);
   localparam logic [IW-1:0]   LAST = IW'(HISTORY_DEPTH - 1);

   logic [IW-1:0]       idx_ff, idx_in;
   logic                found_ff, found_in;
   logic [MED_BITS-1:0] med_ff, med_in;
   logic [MED_BITS-1:0] cand;
   logic [CNTW-1:0]     lt_cnt, le_cnt;
   logic                is_rank;

   // One candidate per cycle is ranked against the whole history.
   always_comb begin
      cand   = hist[idx_ff];
      lt_cnt = '0;
      le_cnt = '0;
      for (int j = 0; j < HISTORY_DEPTH; j++) begin
         lt_cnt = lt_cnt + CNTW'(hist[j] <  cand);
         le_cnt = le_cnt + CNTW'(hist[j] <= cand);
      end
      is_rank = (lt_cnt <= RANK) && (le_cnt > RANK);
      done    = run && (idx_ff == LAST);
      result  = found_ff ? med_ff : cand;
   end

   always_comb begin
      idx_in   = idx_ff;
      found_in = found_ff;
      med_in   = med_ff;
      if (!run || done) begin
         idx_in   = '0;
         found_in = 1'b0;
      end else begin
         idx_in = idx_ff + 1'b1;
         if (!found_ff && is_rank) begin
            found_in = 1'b1;
            med_in   = cand;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         found_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         found_ff <= found_in;
      end
      med_ff <= med_in;
   end

endmodule

/* hw/rtl/qpd_datapath.sv */
module qpd_datapath #(
   parameter int HISTORY_DEPTH = qpd_pkg::DEF_HISTORY_DEPTH,
   parameter int SAMPLE_BITS   = qpd_pkg::DEF_SAMPLE_BITS,
   parameter int COUNT_BITS    = qpd_pkg::DEF_COUNT_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  qpd_pkg::cmd_type                     cmd,
   output qpd_pkg::status_type                  status,
   input  logic signed [SAMPLE_BITS-1:0]        req_filtered_sample,
   input  logic                                 req_restart,
   input  logic                                 csr_write_enable,
   input  logic [qpd_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [qpd_pkg::CSR_DATA_BITS-1:0]    csr_write_data,
   output logic                                 rsp_qrs_detected,
   output logic [qpd_pkg::DELAY_BITS-1:0]       rsp_detection_delay
);
   import qpd_pkg::*;

   localparam int SW   = SAMPLE_BITS;
   localparam int CW   = COUNT_BITS;
   localparam int D    = HISTORY_DEPTH;
   localparam int MW   = (SW > CW) ? SW : CW;
   localparam int SBW  = (CW > SB_START_BITS) ? CW : SB_START_BITS;
   localparam int IW   = (D > 1) ? $clog2(D) : 1;
   localparam int LSW  = $clog2(D + 1);
   localparam int CMPW = ((SW > THR_BITS) ? SW : THR_BITS) + 1;
   localparam int PW   = SW + COEFF_BITS + 2;
   localparam int TW   = PW + 1;
   localparam int DSW  = ((CW > DELAY_BITS) ? CW : DELAY_BITS) + 1;
   localparam logic [CW-1:0]  CNT_MAX   = {CW{1'b1}};
   localparam logic [LSW-1:0] LEARN_END = LSW'(D);
   localparam logic signed [TW-1:0] T_MAX = TW'(65535);
   localparam logic signed [TW-1:0] T_MIN = -(TW'(65536));
   localparam logic [DSW-1:0] DLY_MAX = DSW'(65535);

   // Configuration registers.
   logic [COEFF_BITS-1:0]    coeff_ff;
   logic [TIMEOUT_BITS-1:0]  timeout_ff;
   logic [SECOND_BITS-1:0]   second_ff;
   logic [SB_START_BITS-1:0] sb_start_ff;
   logic [MIN_RR_BITS-1:0]   min_rr_ff;
   logic [PREBLANK_BITS-1:0] preblank_ff;
   logic [WINDOW_BITS-1:0]   window_ff;
   logic [FDELAY_BITS-1:0]   fdelay_ff;

   // Detector state.
   logic signed [SW-1:0] sample_ff, sample_in;
   logic                 restart_ff, restart_in;
   logic signed [SW-1:0] rmax_ff, rmax_in;
   logic [CW-1:0]        tsm_ff, tsm_in;
   logic signed [SW-1:0] prev_ff, prev_in;
   logic signed [SW-1:0] held_ff, held_in;
   logic [7:0]           blank_ff, blank_in;
   logic [LSW-1:0]       ls_ff, ls_in;
   logic [11:0]          tick_ff, tick_in;
   logic signed [SW-1:0] lmax_ff, lmax_in;
   logic [SW-1:0]        qhist_ff [D];
   logic [SW-1:0]        qhist_in [D];
   logic [SW-1:0]        nhist_ff [D];
   logic [SW-1:0]        nhist_in [D];
   logic [CW-1:0]        rhist_ff [D];
   logic [CW-1:0]        rhist_in [D];
   logic [SW-1:0]        qlevel_ff, qlevel_in;
   logic [SW-1:0]        nlevel_ff, nlevel_in;
   logic signed [THR_BITS-1:0] thr_ff, thr_in;
   logic [SBW-1:0]       sb_ff, sb_in;
   logic [CW-1:0]        since_ff, since_in;
   logic signed [SW-1:0] cand_ff, cand_in;
   logic [CW-1:0]        cpos_ff, cpos_in;
   logic signed [PW-1:0] prod_ff, prod_in;
   logic                 hit_ff, hit_in;
   logic [DELAY_BITS-1:0] delay_ff, delay_in;
   logic                 rsp_det_ff;
   logic [DELAY_BITS-1:0] rsp_delay_ff;

   // Per-sample intermediate values.
   logic signed [SW-1:0] x, rmax_e, lmax_e, cand_e, pk, newp, lmax_base;
   logic [CW-1:0]        tsm_e, tsm_inc, since_e, since_inc, interval, back;
   logic [7:0]           blank_e;
   logic [LSW-1:0]       ls_e;
   logic [11:0]          tick_e, tick_inc;
   logic [SBW-1:0]       sb_e;
   logic [SW-1:0]        nhist_b [D];
   logic [CW-1:0]        rhist_b [D];
   logic                 learning, newp_pos, beat, learn_done;
   logic signed [THR_BITS-1:0] thr_half;
   logic [MW-1:0]        med_hist [D];
   logic [D-1:0][MW-1:0] med_bus;
   logic                 med_done;
   logic [MW-1:0]        med_res;
   logic [CW+1:0]        rr_sum;
   logic signed [SW:0]   diff;
   logic signed [PW-1:0] adj, quo;
   logic signed [TW-1:0] tsum;
   logic [DSW-1:0]       dsum;

   always_comb begin
      for (int i = 0; i < D; i++) begin
         case (cmd.med_sel)
            HIST_QRS:   med_hist[i] = MW'(qhist_ff[i]);
            HIST_NOISE: med_hist[i] = MW'(nhist_ff[i]);
            HIST_RR:    med_hist[i] = MW'(rhist_ff[i]);
            default:    med_hist[i] = '0;
         endcase
         med_bus[i] = med_hist[i];
      end
   end

   qpd_median #(
      .HISTORY_DEPTH(D),
      .MED_BITS     (MW)
   ) u_median (
      .clock (clock),
      .reset (reset),
      .run   (cmd.med_run),
      .hist  (med_bus),
      .done  (med_done),
      .result(med_res)
   );

   // Peak finder, pre-blanking and classification of one sample.
   always_comb begin
      x       = sample_ff;
      rmax_e  = restart_ff ? '0 : rmax_ff;
      tsm_e   = restart_ff ? '0 : tsm_ff;
      blank_e = restart_ff ? '0 : blank_ff;
      ls_e    = restart_ff ? '0 : ls_ff;
      tick_e  = restart_ff ? '0 : tick_ff;
      lmax_e  = restart_ff ? '0 : lmax_ff;
      since_e = restart_ff ? '0 : since_ff;
      cand_e  = restart_ff ? '0 : cand_ff;
      sb_e    = restart_ff ? SBW'(sb_start_ff) : sb_ff;
      for (int i = 0; i < D; i++) begin
         nhist_b[i] = restart_ff ? '0 : nhist_ff[i];
         rhist_b[i] = restart_ff ? CW'(second_ff) : rhist_ff[i];
      end

      tsm_inc = tsm_e;
      if (tsm_e != '0) begin
         tsm_inc = (tsm_e == CNT_MAX) ? CNT_MAX : tsm_e + 1'b1;
      end

      pk = '0;
      if ((x > prev_ff) && (x > rmax_e)) begin
         rmax_in = x;
         tsm_in  = (x > SW'(2)) ? CW'(1) : tsm_inc;
      end else if ((x < (rmax_e >>> 1)) || (tsm_inc > CW'(timeout_ff))) begin
         pk      = rmax_e;
         rmax_in = '0;
         tsm_in  = '0;
      end else begin
         rmax_in = rmax_e;
         tsm_in  = tsm_inc;
      end

      newp     = '0;
      held_in  = held_ff;
      blank_in = blank_e;
      if (pk != '0 && blank_e == '0) begin
         held_in  = pk;
         blank_in = preblank_ff;
      end else if (pk == '0 && blank_e != '0) begin
         blank_in = blank_e - 1'b1;
         if (blank_in == '0) newp = held_ff;
      end else if (pk != '0) begin
         if (pk > held_ff) begin
            held_in  = pk;
            blank_in = preblank_ff;
         end else begin
            blank_in = blank_e - 1'b1;
            if (blank_in == '0) newp = held_ff;
         end
      end

      newp_pos  = newp > '0;
      since_inc = (since_e == CNT_MAX) ? CNT_MAX : since_e + 1'b1;
      interval  = (since_inc >= CW'(window_ff)) ? since_inc - CW'(window_ff) : '0;
      learning  = ls_e < LEARN_END;
      tick_inc  = tick_e + 1'b1;
      learn_done = learning && (tick_inc == second_ff) && (ls_e + 1'b1 == LEARN_END);
      beat = !learning && newp_pos &&
             ($signed({{(CMPW-SW){1'b0}}, newp}) >
              $signed({{(CMPW-THR_BITS){thr_ff[THR_BITS-1]}}, thr_ff}));

      thr_half = thr_ff >>> 1;
      back     = (since_ff >= cpos_ff) ? since_ff - cpos_ff : '0;

      status.learn_done = learn_done;
      status.beat       = beat;
      status.noise      = !learning && newp_pos && !beat;
      status.detecting  = !learning;
      status.med_done   = med_done;
      status.sb_hit     = (SBW'(since_ff) > sb_ff) &&
                          ($signed({{(CMPW-SW){1'b0}}, cand_ff}) >
                           $signed({{(CMPW-THR_BITS){thr_half[THR_BITS-1]}}, thr_half}));
   end

   always_comb begin
      sample_in  = sample_ff;
      restart_in = restart_ff;
      prev_in    = prev_ff;
      ls_in      = ls_ff;
      tick_in    = tick_ff;
      lmax_in    = lmax_ff;
      qhist_in   = qhist_ff;
      nhist_in   = nhist_ff;
      rhist_in   = rhist_ff;
      qlevel_in  = qlevel_ff;
      nlevel_in  = nlevel_ff;
      thr_in     = thr_ff;
      sb_in      = sb_ff;
      since_in   = since_ff;
      cand_in    = cand_ff;
      cpos_in    = cpos_ff;
      prod_in    = prod_ff;
      hit_in     = hit_ff;
      delay_in   = delay_ff;
      lmax_base  = lmax_e;
      diff       = $signed({1'b0, qlevel_ff}) - $signed({1'b0, nlevel_ff});
      adj        = prod_ff[PW-1] ? prod_ff + PW'(255) : prod_ff;
      quo        = adj >>> 8;
      tsum       = $signed({quo[PW-1], quo}) + $signed({{(TW-SW){1'b0}}, nlevel_ff});
      rr_sum     = {2'b00, med_res[CW-1:0]} + {3'b000, med_res[CW-1:1]} +
                   (CW+2)'(window_ff);
      dsum       = DSW'(back) + DSW'(fdelay_ff);

      if (cmd.load) begin
         sample_in  = req_filtered_sample;
         restart_in = req_restart;
      end

      if (cmd.front) begin
         hit_in   = 1'b0;
         delay_in = '0;
         prev_in  = x;
         ls_in    = ls_e;
         tick_in  = tick_e;
         sb_in    = sb_e;
         cand_in  = cand_e;
         since_in = since_inc;
         nhist_in = nhist_b;
         rhist_in = rhist_b;
         if (learning) begin
            if (newp_pos) since_in = CW'(window_ff);
            if (tick_inc == second_ff) begin
               tick_in = '0;
               qhist_in[ls_e[IW-1:0]] = lmax_e;
               lmax_base = '0;
               ls_in = ls_e + 1'b1;
               if (learn_done) begin
                  nlevel_in = '0;
                  sb_in     = SBW'(sb_start_ff);
               end
            end else begin
               tick_in = tick_inc;
            end
            lmax_in = (newp > lmax_base) ? newp : lmax_base;
         end else begin
            lmax_in = lmax_e;
            if (beat) begin
               for (int i = D - 1; i > 0; i--) begin
                  qhist_in[i] = qhist_ff[i-1];
                  rhist_in[i] = rhist_b[i-1];
               end
               qhist_in[0] = newp;
               rhist_in[0] = interval;
               cand_in  = '0;
               tick_in  = '0;
               lmax_in  = '0;
               since_in = CW'(window_ff);
               hit_in   = 1'b1;
               delay_in = DELAY_BITS'(window_ff) + DELAY_BITS'(fdelay_ff);
            end else if (newp_pos) begin
               for (int i = D - 1; i > 0; i--) nhist_in[i] = nhist_b[i-1];
               nhist_in[0] = newp;
               if ((newp > cand_e) && (interval >= CW'(min_rr_ff))) begin
                  cand_in = newp;
                  cpos_in = interval;
               end
            end
         end
      end

      if (cmd.med_run && med_done) begin
         case (cmd.med_sel)
            HIST_QRS:   qlevel_in = med_res[SW-1:0];
            HIST_NOISE: nlevel_in = med_res[SW-1:0];
            HIST_RR:    sb_in = (rr_sum > (CW+2)'(CNT_MAX)) ? SBW'(CNT_MAX) : SBW'(rr_sum);
            default:    sb_in = sb_ff;
         endcase
      end

      if (cmd.mul) prod_in = PW'(diff * $signed({1'b0, coeff_ff}));

      if (cmd.thr) begin
         if (tsum > T_MAX)      thr_in = T_MAX[THR_BITS-1:0];
         else if (tsum < T_MIN) thr_in = T_MIN[THR_BITS-1:0];
         else                   thr_in = tsum[THR_BITS-1:0];
      end

      // Search-back: the best late noise peak is taken as the missed beat.
      if (cmd.sb && status.sb_hit) begin
         for (int i = D - 1; i > 0; i--) begin
            qhist_in[i] = qhist_ff[i-1];
            rhist_in[i] = rhist_ff[i-1];
         end
         qhist_in[0] = cand_ff;
         rhist_in[0] = cpos_ff;
         cand_in  = '0;
         tick_in  = '0;
         lmax_in  = '0;
         since_in = back;
         hit_in   = 1'b1;
         delay_in = (dsum > DLY_MAX) ? DELAY_BITS'(DLY_MAX) : dsum[DELAY_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coeff_ff    <= RST_COEFF;
         timeout_ff  <= RST_TIMEOUT;
         second_ff   <= RST_SECOND;
         sb_start_ff <= RST_SB_START;
         min_rr_ff   <= RST_MIN_RR;
         preblank_ff <= RST_PREBLANK;
         window_ff   <= RST_WINDOW;
         fdelay_ff   <= RST_FDELAY;
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            REG_COEFF:        coeff_ff    <= csr_write_data[COEFF_BITS-1:0];
            REG_TIMEOUT:      timeout_ff  <= csr_write_data[TIMEOUT_BITS-1:0];
            REG_SECOND_LEN:   second_ff   <= csr_write_data[SECOND_BITS-1:0];
            REG_SB_START:     sb_start_ff <= csr_write_data[SB_START_BITS-1:0];
            REG_MIN_RR:       min_rr_ff   <= csr_write_data[MIN_RR_BITS-1:0];
            REG_PREBLANK:     preblank_ff <= csr_write_data[PREBLANK_BITS-1:0];
            REG_WINDOW:       window_ff   <= csr_write_data[WINDOW_BITS-1:0];
            REG_FILTER_DELAY: fdelay_ff   <= csr_write_data[FDELAY_BITS-1:0];
            default:          coeff_ff    <= coeff_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rmax_ff   <= '0;
         tsm_ff    <= '0;
         prev_ff   <= '0;
         held_ff   <= '0;
         blank_ff  <= '0;
         ls_ff     <= '0;
         tick_ff   <= '0;
         lmax_ff   <= '0;
         qlevel_ff <= '0;
         nlevel_ff <= '0;
         thr_ff    <= '0;
         sb_ff     <= SBW'(RST_SB_START);
         since_ff  <= '0;
         cand_ff   <= '0;
         cpos_ff   <= '0;
         hit_ff    <= 1'b0;
         delay_ff  <= '0;
         for (int i = 0; i < D; i++) begin
            qhist_ff[i] <= '0;
            nhist_ff[i] <= '0;
            rhist_ff[i] <= CW'(RST_SECOND);
         end
      end else begin
         rmax_ff   <= cmd.front ? rmax_in  : rmax_ff;
         tsm_ff    <= cmd.front ? tsm_in   : tsm_ff;
         held_ff   <= cmd.front ? held_in  : held_ff;
         blank_ff  <= cmd.front ? blank_in : blank_ff;
         prev_ff   <= prev_in;
         ls_ff     <= ls_in;
         tick_ff   <= tick_in;
         lmax_ff   <= lmax_in;
         qlevel_ff <= qlevel_in;
         nlevel_ff <= nlevel_in;
         thr_ff    <= thr_in;
         sb_ff     <= sb_in;
         since_ff  <= since_in;
         cand_ff   <= cand_in;
         cpos_ff   <= cpos_in;
         hit_ff    <= hit_in;
         delay_ff  <= delay_in;
         qhist_ff  <= qhist_in;
         nhist_ff  <= nhist_in;
         rhist_ff  <= rhist_in;
      end
      sample_ff  <= sample_in;
      restart_ff <= restart_in;
      prod_ff    <= prod_in;
      if (cmd.out_load) begin
         rsp_det_ff   <= hit_ff;
         rsp_delay_ff <= hit_ff ? delay_ff : '0;
      end
   end

   assign rsp_qrs_detected    = rsp_det_ff;
   assign rsp_detection_delay = rsp_delay_ff;

endmodule

/* hw/rtl/qpd_ctrl.sv */
module qpd_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  qpd_pkg::status_type status,
   output qpd_pkg::cmd_type    cmd
);
   import qpd_pkg::*;

   state_type state_ff, state_in;
   mode_type  mode_ff, mode_in;
   logic      sb_fired_ff, sb_fired_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in    = state_ff;
      mode_in     = mode_ff;
      sb_fired_in = sb_fired_ff;
      case (state_ff)
         ST_IDLE: if (req_valid) state_in = ST_FRONT;
         ST_FRONT: begin
            sb_fired_in = 1'b0;
            if (status.learn_done) begin
               mode_in  = MODE_LEARN;
               state_in = ST_MED_Q;
            end else if (status.beat) begin
               mode_in  = MODE_BEAT;
               state_in = ST_MED_Q;
            end else if (status.noise) begin
               mode_in  = MODE_NOISE;
               state_in = ST_MED_N;
            end else if (status.detecting) begin
               state_in = ST_SB;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_MED_Q: if (status.med_done) state_in = ST_MUL;
         ST_MED_N: if (status.med_done) state_in = ST_MUL;
         ST_MUL:   state_in = ST_THR;
         ST_THR: begin
            case (mode_ff)
               MODE_LEARN: state_in = ST_OUT;
               MODE_BEAT:  state_in = ST_MED_R;
               MODE_NOISE: state_in = ST_SB;
               default:    state_in = ST_OUT;
            endcase
         end
         ST_MED_R: if (status.med_done) state_in = sb_fired_ff ? ST_OUT : ST_SB;
         ST_SB: begin
            if (status.sb_hit) begin
               mode_in     = MODE_BEAT;
               sb_fired_in = 1'b1;
               state_in    = ST_MED_Q;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: if (!rsp_valid_ff || !rsp_stall) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd          = '0;
      cmd.med_sel  = HIST_QRS;
      req_stall    = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         ST_FRONT: cmd.front = 1'b1;
         ST_MED_Q: cmd.med_run = 1'b1;
         ST_MED_N: begin
            cmd.med_run = 1'b1;
            cmd.med_sel = HIST_NOISE;
         end
         ST_MED_R: begin
            cmd.med_run = 1'b1;
            cmd.med_sel = HIST_RR;
         end
         ST_MUL: cmd.mul = 1'b1;
         ST_THR: cmd.thr = 1'b1;
         ST_SB:  cmd.sb  = 1'b1;
         ST_OUT: cmd.out_load = !rsp_valid_ff || !rsp_stall;
         default: cmd = '0;
      endcase
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load)        rsp_valid_in = 1'b1;
      else if (!rsp_stall)     rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= MODE_LEARN;
         sb_fired_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         sb_fired_ff  <= sb_fired_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

/* hw/rtl/qrs_peak_detector_core.sv */
// QRS peak detector core: the decision stage of a QRS detector.
// The request channel (req_valid, req_stall, req_filtered_sample, req_restart)
// carries one filtered ECG sample per request; the response channel (rsp_valid,
// rsp_stall, rsp_qrs_detected, rsp_detection_delay) returns exactly one result
// per request, in order. The csr_ port writes the eight tuning registers; the user
// must use it only while the core is idle, and the core does not enforce this.
// One request is worked on at a time. While learning, a sample passes through
// the FRONT and OUT steps, and the last one adds a QRS median and a threshold
// update; once detection runs, a sample without a finished peak also passes
// the search-back step. A noise peak adds a noise median and the threshold
// update; a beat adds two medians and the threshold update; a search-back beat
// adds the same again. The next request can be taken in the cycle after the
// response is written. The shared median unit ranks one history entry per cycle.
// A new request may be accepted while the previous response still waits.
// While the receiver stalls, the response register holds its value and the
// core stops before writing the next response.
// Synchronous reset returns the control, configuration and detector registers
// to their documented reset values with no clearing pass, and the core accepts
// a request in the next cycle; sample, product and response data are not reset.
module qrs_peak_detector_core #(
   parameter int HISTORY_DEPTH = qpd_pkg::DEF_HISTORY_DEPTH,
   parameter int SAMPLE_BITS   = qpd_pkg::DEF_SAMPLE_BITS,
   parameter int COUNT_BITS    = qpd_pkg::DEF_COUNT_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [SAMPLE_BITS-1:0]      req_filtered_sample,
   input  logic                               req_restart,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_qrs_detected,
   output logic [qpd_pkg::DELAY_BITS-1:0]     rsp_detection_delay,
   input  logic                               csr_write_enable,
   input  logic [qpd_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [qpd_pkg::CSR_DATA_BITS-1:0]  csr_write_data
);
   import qpd_pkg::*;

   // Commands from the controller and status back from the datapath.
   cmd_type    cmd;
   status_type status;

   // The controller sequences each request through the datapath steps.
   qpd_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .status   (status),
      .cmd      (cmd)
   );

   // The datapath holds the peak finder, histories, levels and threshold.
   qpd_datapath #(
      .HISTORY_DEPTH(HISTORY_DEPTH),
      .SAMPLE_BITS  (SAMPLE_BITS),
      .COUNT_BITS   (COUNT_BITS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_filtered_sample(req_filtered_sample),
      .req_restart        (req_restart),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .rsp_qrs_detected   (rsp_qrs_detected),
      .rsp_detection_delay(rsp_detection_delay)
   );

endmodule

/* hw/rtl/qpd_checker.sv */
`include "qrs_peak_detector_core_macros.svh"

module qpd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_qrs_detected,
   input logic [15:0] rsp_detection_delay
);

   `QPD_ASSERT(a_rsp_held, rsp_valid && rsp_stall |=> rsp_valid, "response dropped while stalled")
   `QPD_NEVER(a_delay_zero, rsp_valid && !rsp_qrs_detected && (rsp_detection_delay != 16'd0), "delay without beat")
   `QPD_ASSERT(a_one_at_a_time, req_valid && !req_stall |=> req_stall, "request taken while busy")
   `QPD_ASSERT(a_rsp_after_work, $rose(rsp_valid) |-> $past(req_stall), "response without work")

endmodule

bind qrs_peak_detector_core qpd_checker u_qpd_checker (.*);
